FILE: hw/rtl/epc_pkg.sv
// ----------------------------------------------------------------------------
// Encoder PID position controller package
// Shared codes, state encoding and fixed constants of the position controller.
// ----------------------------------------------------------------------------
package epc_pkg;

    localparam int CFG_COUNT = 6;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_COUNTS_TO_ANGLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P          = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ANGLE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND       = 3'd5;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam logic [2:0] PHASE_NONE = 3'd0;
    localparam logic [2:0] PHASE_1    = 3'd1;
    localparam logic [2:0] PHASE_2    = 3'd2;
    localparam logic [2:0] PHASE_3    = 3'd3;
    localparam logic [2:0] PHASE_4    = 3'd4;

    localparam int DIGIT_W         = 32;
    localparam int PROD_W          = CFG_W + DIGIT_W;
    localparam int PROD_LIMIT_LOG2 = 60;
    localparam int PID_W           = 64;
    localparam logic [7:0] PID_MAX = 8'd255;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_LOAD  = 8'b0000_0010,
        ST_MUL   = 8'b0000_0100,
        ST_ANGLE = 8'b0000_1000,
        ST_ERR   = 8'b0001_0000,
        ST_UPD   = 8'b0010_0000,
        ST_ACC   = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } state_t;

    typedef enum logic [1:0] {
        TERM_ANGLE = 2'd0,
        TERM_P     = 2'd1,
        TERM_I     = 2'd2,
        TERM_D     = 2'd3
    } term_t;

endpackage

FILE: hw/rtl/encoder_pid_position_controller_unit.sv
// ----------------------------------------------------------------------------
// Encoder PID position controller
// Quadrature position counter with a saturating fixed-point PID controller.
// ----------------------------------------------------------------------------
// The slave channel carries one item per transfer: s_tuser selects an encoder
// sample (0) or a control tick (1), and s_tdata holds the A and B levels.
// An encoder sample updates the position count in the cycle it is accepted,
// produces no result, and s_tready stays high.
// A control tick runs the products through one shared 16 x 32 multiplier
// that accumulates one 32-bit digit per cycle. With NC = ceil(COUNT_WIDTH/32)
// and NS = ceil(SUM_WIDTH/32), the angle product takes NC digits and the P, I
// and D products NS digits each; s_tready is low until the tick is done, and
// the output step registers the result onto the master channel.
// The result sits in an output register, so a new item is taken while a
// result still waits; a tick that finishes while the master channel stalls
// holds in its last step until the register is free.
// The configuration port writes one register per enabled cycle and should
// be used only while the block is idle.
// Reset clears the configuration registers, the count, the phase history, the
// integral and the stored error.
// ----------------------------------------------------------------------------
module encoder_pid_position_controller_unit #(
    parameter int COUNT_WIDTH = 32,
    parameter int SUM_WIDTH   = 48
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_wr_en,
    input  logic [epc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [epc_pkg::CFG_W-1:0]       cfg_wr_data,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // enc_a, enc_b, zero fill
    input  logic [0:0]                      s_tuser,   // op

    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [47:0]                     m_tdata    // drive_forward, drive_reverse,
                                                       // pwm_duty, position_count,
                                                       // zero fill
);

    localparam int DW    = epc_pkg::DIGIT_W;
    localparam int NDC   = (COUNT_WIDTH + DW - 1) / DW;
    localparam int NDS   = (SUM_WIDTH + DW - 1) / DW;
    localparam int NDM   = (NDC > NDS) ? NDC : NDS;
    localparam int OPW   = NDM * DW;
    localparam int ACCW  = OPW + epc_pkg::CFG_W;
    localparam int SATW  = (ACCW > epc_pkg::PROD_LIMIT_LOG2 + 1) ?
                           ACCW : epc_pkg::PROD_LIMIT_LOG2 + 1;
    localparam int AW    = COUNT_WIDTH + epc_pkg::CFG_W + 1;
    localparam int DIFW  = ((AW > 24) ? AW : 24) + 2;
    localparam int XW    = (DIFW > SUM_WIDTH + 1) ? DIFW : SUM_WIDTH + 1;
    localparam int DCW   = $clog2(NDM + 1);
    localparam int SHC   = DW * (NDM - NDC);
    localparam int SHS   = DW * (NDM - NDS);
    localparam int PW    = epc_pkg::PID_W;

    localparam logic [DCW-1:0] NDC_CNT = DCW'(NDC);
    localparam logic [DCW-1:0] NDS_CNT = DCW'(NDS);
    localparam logic [DCW-1:0] ONE_CNT = DCW'(1);

    localparam logic signed [XW-1:0] SUM_MAX =
        {{(XW - SUM_WIDTH + 1){1'b0}}, {(SUM_WIDTH - 1){1'b1}}};
    localparam logic signed [XW-1:0] SUM_MIN = ~SUM_MAX;
    localparam logic [SATW-1:0] PROD_LIMIT = SATW'(1) << epc_pkg::PROD_LIMIT_LOG2;

    function automatic logic signed [SUM_WIDTH-1:0] sat_sum(
        input logic signed [XW-1:0] v
    );
        logic signed [SUM_WIDTH-1:0] r;
        if (v > SUM_MAX) begin
            r = SUM_MAX[SUM_WIDTH-1:0];
        end else if (v < SUM_MIN) begin
            r = SUM_MIN[SUM_WIDTH-1:0];
        end else begin
            r = v[SUM_WIDTH-1:0];
        end
        return r;
    endfunction

    // Configuration registers
    logic [epc_pkg::CFG_W-1:0]        cta_reg;
    logic signed [epc_pkg::CFG_W-1:0] gain_p_reg;
    logic signed [epc_pkg::CFG_W-1:0] gain_i_reg;
    logic signed [epc_pkg::CFG_W-1:0] gain_d_reg;
    logic signed [epc_pkg::CFG_W-1:0] target_reg;
    logic [epc_pkg::CFG_W-1:0]        band_reg;

    // Controller state
    epc_pkg::state_t                  state_reg, state_next;
    epc_pkg::term_t                   term_reg, term_next;
    logic signed [COUNT_WIDTH-1:0]    count_reg, count_next;
    logic [2:0]                       phase_reg, phase_next;
    logic signed [SUM_WIDTH-1:0]      sum_reg, sum_next;
    logic signed [SUM_WIDTH-1:0]      prev_err_reg, prev_err_next;

    // Work registers
    logic [DCW-1:0]                   digit_reg, digit_next;
    logic [epc_pkg::CFG_W-1:0]        mg_reg, mg_next;
    logic [OPW-1:0]                   opnd_reg, opnd_next;
    logic [ACCW-1:0]                  acc_reg, acc_next;
    logic                             neg_reg, neg_next;
    logic signed [AW-1:0]             angle_reg, angle_next;
    logic signed [SUM_WIDTH-1:0]      err_reg, err_next;
    logic signed [SUM_WIDTH-1:0]      chg_reg, chg_next;
    logic signed [PW-1:0]             pid_reg, pid_next;
    logic                             fwd_reg, fwd_next;
    logic                             rev_reg, rev_next;

    // Output register
    logic                             m_valid_reg, m_valid_next;
    logic [47:0]                      m_data_reg, m_data_next;

    logic                             s_xfer;
    logic                             m_free;
    logic                             in_a, in_b;
    logic [2:0]                       ph_cur, ph_up, ph_dn;

    logic [epc_pkg::PROD_W-1:0]       prod;
    logic [COUNT_WIDTH-1:0]           mag_c;
    logic signed [SUM_WIDTH-1:0]      val_s;
    logic [SUM_WIDTH-1:0]             mag_s;
    logic signed [epc_pkg::CFG_W-1:0] gain_s;
    logic [epc_pkg::CFG_W-1:0]        mag_g;
    logic [AW-1:0]                    angle_mag;
    logic signed [XW-1:0]             tgt_x, angle_x, band_x;
    logic [SATW-1:0]                  acc_ext, term_mag;
    logic signed [PW-1:0]             term_s;
    logic [PW-1:0]                    pid_mag;
    logic [7:0]                       duty;
    logic [COUNT_WIDTH+31:0]          count_ext;

    assign s_tready = (state_reg == epc_pkg::ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign m_free   = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign in_a = s_tdata[0];
    assign in_b = s_tdata[1];

    always_comb begin
        if (in_a) begin
            ph_cur = in_b ? epc_pkg::PHASE_1 : epc_pkg::PHASE_2;
        end else begin
            ph_cur = in_b ? epc_pkg::PHASE_4 : epc_pkg::PHASE_3;
        end
        ph_up = (ph_cur == epc_pkg::PHASE_4) ? epc_pkg::PHASE_1 : ph_cur + 3'd1;
        ph_dn = (ph_cur == epc_pkg::PHASE_1) ? epc_pkg::PHASE_4 : ph_cur - 3'd1;
    end

    // Shared multiplier: the counts-to-angle factor or a gain magnitude times the top digit of the operand.
    assign prod = mg_reg * opnd_reg[OPW-1 -: DW];

    assign mag_c = count_reg[COUNT_WIDTH-1] ? COUNT_WIDTH'(-count_reg)
                                            : COUNT_WIDTH'(count_reg);

    always_comb begin
        unique case (term_reg)
            epc_pkg::TERM_P: begin
                val_s  = err_reg;
                gain_s = gain_p_reg;
            end
            epc_pkg::TERM_I: begin
                val_s  = sum_reg;
                gain_s = gain_i_reg;
            end
            default: begin
                val_s  = chg_reg;
                gain_s = gain_d_reg;
            end
        endcase
    end

    assign mag_s = val_s[SUM_WIDTH-1] ? SUM_WIDTH'(-val_s) : SUM_WIDTH'(val_s);
    assign mag_g = gain_s[epc_pkg::CFG_W-1] ? epc_pkg::CFG_W'(-gain_s)
                                           : epc_pkg::CFG_W'(gain_s);

    assign angle_mag = AW'(acc_reg);
    assign tgt_x     = XW'(target_reg) <<< 8;
    assign angle_x   = XW'(angle_reg);
    assign band_x    = signed'(XW'(band_reg));

    assign acc_ext  = SATW'(acc_reg);
    assign term_mag = (acc_ext > PROD_LIMIT) ? PROD_LIMIT : acc_ext;
    assign term_s   = signed'(PW'(term_mag));

    assign pid_mag = pid_reg[PW-1] ? PW'(-pid_reg) : PW'(pid_reg);
    assign duty    = (pid_mag[PW-1:24] != '0) ? epc_pkg::PID_MAX : pid_mag[23:16];

    assign count_ext = {32'd0, count_reg};

    always_comb begin
        state_next    = state_reg;
        term_next     = term_reg;
        count_next    = count_reg;
        phase_next    = phase_reg;
        sum_next      = sum_reg;
        prev_err_next = prev_err_reg;
        digit_next    = digit_reg;
        mg_next       = mg_reg;
        opnd_next     = opnd_reg;
        acc_next      = acc_reg;
        neg_next      = neg_reg;
        angle_next    = angle_reg;
        err_next      = err_reg;
        chg_next      = chg_reg;
        pid_next      = pid_reg;
        fwd_next      = fwd_reg;
        rev_next      = rev_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;

        unique case (state_reg)
            epc_pkg::ST_IDLE: begin
                if (s_xfer) begin
                    if (s_tuser[0] == epc_pkg::OP_TICK) begin
                        term_next  = epc_pkg::TERM_ANGLE;
                        pid_next   = '0;
                        state_next = epc_pkg::ST_LOAD;
                    end else begin
                        if (phase_reg == ph_up) begin
                            count_next = count_reg + COUNT_WIDTH'(1);
                        end else if (phase_reg == ph_dn) begin
                            count_next = count_reg - COUNT_WIDTH'(1);
                        end
                        phase_next = ph_cur;
                    end
                end
            end
            epc_pkg::ST_LOAD: begin
                acc_next = '0;
                if (term_reg == epc_pkg::TERM_ANGLE) begin
                    mg_next    = cta_reg;
                    opnd_next  = OPW'(mag_c) << SHC;
                    neg_next   = count_reg[COUNT_WIDTH-1];
                    digit_next = NDC_CNT;
                end else begin
                    mg_next    = mag_g;
                    opnd_next  = OPW'(mag_s) << SHS;
                    neg_next   = gain_s[epc_pkg::CFG_W-1] ^ val_s[SUM_WIDTH-1];
                    digit_next = NDS_CNT;
                end
                state_next = epc_pkg::ST_MUL;
            end
            epc_pkg::ST_MUL: begin
                acc_next   = (acc_reg << DW) + ACCW'(prod);
                opnd_next  = opnd_reg << DW;
                digit_next = digit_reg - ONE_CNT;
                if (digit_reg == ONE_CNT) begin
                    state_next = (term_reg == epc_pkg::TERM_ANGLE) ? epc_pkg::ST_ANGLE
                                                                   : epc_pkg::ST_ACC;
                end
            end
            epc_pkg::ST_ANGLE: begin
                angle_next = neg_reg ? -signed'(angle_mag) : signed'(angle_mag);
                state_next = epc_pkg::ST_ERR;
            end
            epc_pkg::ST_ERR: begin
                err_next = sat_sum(tgt_x - angle_x);
                if ((angle_x <= tgt_x + band_x) && (angle_x >= tgt_x - band_x)) begin
                    fwd_next = 1'b0;
                    rev_next = 1'b0;
                end else begin
                    fwd_next = (angle_x < tgt_x);
                    rev_next = !(angle_x < tgt_x);
                end
                state_next = epc_pkg::ST_UPD;
            end
            epc_pkg::ST_UPD: begin
                chg_next      = sat_sum(XW'(err_reg) - XW'(prev_err_reg));
                sum_next      = sat_sum(XW'(sum_reg) + XW'(err_reg));
                prev_err_next = err_reg;
                term_next     = epc_pkg::TERM_P;
                state_next    = epc_pkg::ST_LOAD;
            end
            epc_pkg::ST_ACC: begin
                pid_next = pid_reg + (neg_reg ? -term_s : term_s);
                unique case (term_reg)
                    epc_pkg::TERM_P: begin
                        term_next  = epc_pkg::TERM_I;
                        state_next = epc_pkg::ST_LOAD;
                    end
                    epc_pkg::TERM_I: begin
                        term_next  = epc_pkg::TERM_D;
                        state_next = epc_pkg::ST_LOAD;
                    end
                    default: begin
                        state_next = epc_pkg::ST_OUT;
                    end
                endcase
            end
            epc_pkg::ST_OUT: begin
                if (m_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {6'd0, count_ext[31:0], duty, rev_reg, fwd_reg};
                    state_next   = epc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = epc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cta_reg      <= '0;
            gain_p_reg   <= '0;
            gain_i_reg   <= '0;
            gain_d_reg   <= '0;
            target_reg   <= '0;
            band_reg     <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                epc_pkg::CFG_COUNTS_TO_ANGLE: cta_reg    <= cfg_wr_data;
                epc_pkg::CFG_GAIN_P:          gain_p_reg <= signed'(cfg_wr_data);
                epc_pkg::CFG_GAIN_I:          gain_i_reg <= signed'(cfg_wr_data);
                epc_pkg::CFG_GAIN_D:          gain_d_reg <= signed'(cfg_wr_data);
                epc_pkg::CFG_TARGET_ANGLE:    target_reg <= signed'(cfg_wr_data);
                epc_pkg::CFG_DEAD_BAND:       band_reg   <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= epc_pkg::ST_IDLE;
            term_reg     <= epc_pkg::TERM_ANGLE;
            count_reg    <= '0;
            phase_reg    <= epc_pkg::PHASE_NONE;
            sum_reg      <= '0;
            prev_err_reg <= '0;
            digit_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            term_reg     <= term_next;
            count_reg    <= count_next;
            phase_reg    <= phase_next;
            sum_reg      <= sum_next;
            prev_err_reg <= prev_err_next;
            digit_reg    <= digit_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mg_reg     <= mg_next;
        opnd_reg   <= opnd_next;
        acc_reg    <= acc_next;
        neg_reg    <= neg_next;
        angle_reg  <= angle_next;
        err_reg    <= err_next;
        chg_reg    <= chg_next;
        pid_reg    <= pid_next;
        fwd_reg    <= fwd_next;
        rev_reg    <= rev_next;
        m_data_reg <= m_data_next;
    end

    // A tick always starts with the angle product.
    a_tick_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && s_tuser[0] == epc_pkg::OP_TICK) |=>
            (state_reg == epc_pkg::ST_LOAD && term_reg == epc_pkg::TERM_ANGLE))
        else $error("tick transfer did not start the angle product");

    // An encoder sample is finished in the cycle of its transfer.
    a_sample_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && s_tuser[0] == epc_pkg::OP_SAMPLE) |=> (state_reg == epc_pkg::ST_IDLE))
        else $error("encoder sample left the controller busy");

    // A result is only presented after the final step of a tick.
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == epc_pkg::ST_OUT))
        else $error("result presented outside the output step");

    // The digit counter never runs out while the multiplier is in use.
    a_digit_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == epc_pkg::ST_MUL) |-> (digit_reg != '0))
        else $error("multiply step entered with no digits left");

endmodule
